>>> design/pcm_pkg.sv
// Shared definitions for the multimode PID controller: register indexes, mode codes,
// microcode control word layout and the microprogram itself.
// Used by pcm_seq and pid_controller_multimode; depends on nothing else.
`timescale 1ns / 1ps

package pcm_pkg;

	// Fixed-point format and clamp bounds.
	localparam int FRAC_BITS = 16;
	localparam logic signed [32:0] WINDUP_HIGH = 33'sd2147483647;
	localparam logic signed [32:0] WINDUP_LOW = -33'sd2147483647;
	localparam logic [47:0] SAT48 = 48'h7FFF_FFFF_FFFF;

	// Configuration register indexes.
	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_GAIN_P = 3'd1;
	localparam logic [2:0] REG_GAIN_I = 3'd2;
	localparam logic [2:0] REG_GAIN_D = 3'd3;
	localparam logic [2:0] REG_INTEG_LIMIT = 3'd4;
	localparam logic [2:0] REG_OUT_LIMIT = 3'd5;
	localparam logic [2:0] REG_SEP_BAND = 3'd6;
	localparam logic [2:0] REG_DERIV_ALPHA = 3'd7;

	// Controller variants.
	localparam logic [2:0] MODE_PLAIN = 3'd0;
	localparam logic [2:0] MODE_SEPARATE = 3'd1;
	localparam logic [2:0] MODE_ANTIWINDUP = 3'd2;
	localparam logic [2:0] MODE_TRAPEZOID = 3'd3;
	localparam logic [2:0] MODE_FILTERED = 3'd4;

	// Multiplier operand A selects.
	localparam logic [1:0] A_GAIN_P = 2'd0;
	localparam logic [1:0] A_GAIN_I = 2'd1;
	localparam logic [1:0] A_GAIN_D = 2'd2;
	localparam logic [1:0] A_ALPHA = 2'd3;

	// Multiplier operand B selects.
	localparam logic [2:0] B_ERR = 3'd0;
	localparam logic [2:0] B_DIFF = 3'd1;
	localparam logic [2:0] B_IERR = 3'd2;
	localparam logic [2:0] B_RAW_LO = 3'd3;
	localparam logic [2:0] B_RAW_HI = 3'd4;
	localparam logic [2:0] B_PD_LO = 3'd5;
	localparam logic [2:0] B_PD_HI = 3'd6;

	// Datapath operations.
	localparam logic [3:0] OP_NOP = 4'd0;
	localparam logic [3:0] OP_LOAD_P = 4'd1;
	localparam logic [3:0] OP_LOAD_D = 4'd2;
	localparam logic [3:0] OP_ISUM = 4'd3;
	localparam logic [3:0] OP_RAW = 4'd4;
	localparam logic [3:0] OP_T_LOAD = 4'd5;
	localparam logic [3:0] OP_T_ACC = 4'd6;
	localparam logic [3:0] OP_T_SUB = 4'd7;
	localparam logic [3:0] OP_F_SHIFT = 4'd8;
	localparam logic [3:0] OP_F_DONE = 4'd9;
	localparam logic [3:0] OP_INTEG = 4'd10;
	localparam logic [3:0] OP_TOTAL = 4'd11;
	localparam logic [3:0] OP_OUT = 4'd12;

	localparam int NUM_STEPS = 14;
	localparam int PC_W = $clog2(NUM_STEPS);
	localparam logic [PC_W-1:0] STEP_INTEG = PC_W'(11);

	typedef struct packed {
		logic [1:0] a_sel;
		logic [2:0] b_sel;
		logic [3:0] op;
		logic skip;               // jump to target unless the filtered mode is on
		logic [PC_W-1:0] target;
		logic last;
	} ctrl_t;

	function automatic ctrl_t uword(input logic [1:0] a, input logic [2:0] b,
			input logic [3:0] op, input logic skip, input logic last);
		ctrl_t w;
		w.a_sel = a;
		w.b_sel = b;
		w.op = op;
		w.skip = skip;
		w.target = STEP_INTEG;
		w.last = last;
		return w;
	endfunction

	// The microprogram. A multiply issued in one step shows up in the product
	// register during the next step.
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		case (pc)
			PC_W'(0): w = uword(A_GAIN_P, B_ERR, OP_NOP, 1'b0, 1'b0);
			PC_W'(1): w = uword(A_GAIN_D, B_DIFF, OP_LOAD_P, 1'b0, 1'b0);
			PC_W'(2): w = uword(A_GAIN_I, B_IERR, OP_LOAD_D, 1'b0, 1'b0);
			PC_W'(3): w = uword(A_GAIN_P, B_ERR, OP_ISUM, 1'b1, 1'b0);
			PC_W'(4): w = uword(A_GAIN_P, B_ERR, OP_RAW, 1'b0, 1'b0);
			PC_W'(5): w = uword(A_ALPHA, B_RAW_LO, OP_NOP, 1'b0, 1'b0);
			PC_W'(6): w = uword(A_ALPHA, B_RAW_HI, OP_T_LOAD, 1'b0, 1'b0);
			PC_W'(7): w = uword(A_ALPHA, B_PD_LO, OP_T_ACC, 1'b0, 1'b0);
			PC_W'(8): w = uword(A_ALPHA, B_PD_HI, OP_T_SUB, 1'b0, 1'b0);
			PC_W'(9): w = uword(A_GAIN_P, B_ERR, OP_F_SHIFT, 1'b0, 1'b0);
			PC_W'(10): w = uword(A_GAIN_P, B_ERR, OP_F_DONE, 1'b0, 1'b0);
			PC_W'(11): w = uword(A_GAIN_P, B_ERR, OP_INTEG, 1'b0, 1'b0);
			PC_W'(12): w = uword(A_GAIN_P, B_ERR, OP_TOTAL, 1'b0, 1'b0);
			PC_W'(13): w = uword(A_GAIN_P, B_ERR, OP_OUT, 1'b0, 1'b1);
			default: w = uword(A_GAIN_P, B_ERR, OP_NOP, 1'b0, 1'b1);
		endcase
		return w;
	endfunction

endpackage

>>> design/pcm_seq.sv
// Microcode sequencer for the PID controller: step counter, program ROM and the
// skip jump around the derivative filter. Depends on pcm_pkg.
`timescale 1ns / 1ps

module pcm_seq (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic filt,
	input logic hold,
	output logic busy,
	output logic active,
	output pcm_pkg::ctrl_t ctrl
);
	import pcm_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic busy_q;

	assign ctrl = ucode(pc_q);
	assign busy = busy_q;
	// The last step waits while the output register still holds a result.
	assign active = busy_q && !(ctrl.last && hold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			pc_q <= '0;
			busy_q <= 1'b1;
		end else if (active) begin
			if (ctrl.last) begin
				busy_q <= 1'b0;
			end else if (ctrl.skip && !filt) begin
				pc_q <= ctrl.target;
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end
		end
	end

endmodule

>>> design/pid_controller_multimode.sv
// Top level of the multimode positional PID controller: configuration registers,
// shared multiplier datapath and output register. Depends on pcm_pkg and pcm_seq.
`timescale 1ns / 1ps

// Usage. Configuration registers are written over the cfg channel (cfg_index selects
// mode, gain_p, gain_i, gain_d, integ_limit, out_limit, sep_band, deriv_alpha in that
// order); cfg_ready is always high, and writes belong in periods when no request is
// in flight. Each request on the s_axis channel carries a setpoint and a measurement;
// each produces exactly one result on m_axis: the clamped drive value in tdata and
// the clamp flag in tuser.
// Timing. A microprogram runs each request through one shared 33x27 multiplier, one
// step per cycle except that the final step waits while the output register is full.
// Modes 0 to 3 take 7 steps after the accepting edge; the filtered derivative mode
// takes 14, because its two Q0.16 products are split into four partial products on
// the same multiplier. A new request is accepted the cycle after the previous result
// has been loaded into the output register.
// Stalls. The output register holds a result until m_axis_tready takes it; the next
// request can be accepted and worked on meanwhile, and only its final step waits.
// Reset. arst_n clears the controller state (previous error, integrator, filtered
// derivative, previous output) to zero, loads the register reset values, and
// empties the output register.
module pid_controller_multimode (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [47:0] s_axis_tdata,    // [23:0] setpoint, [47:24] measured
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] drive
	output logic [0:0] m_axis_tuser,    // [0] clamped
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	import pcm_pkg::*;

	// Configuration registers.
	logic [2:0] mode_q;
	logic [31:0] gain_p_q, gain_i_q, gain_d_q;
	logic [30:0] integ_limit_q, out_limit_q;
	logic [23:0] sep_band_q;
	logic [15:0] deriv_alpha_q;

	// Controller state.
	logic signed [24:0] prev_error_q;
	logic signed [47:0] integ_q;
	logic signed [47:0] prev_deriv_q;
	logic signed [31:0] prev_out_q;

	// Working registers for one request.
	logic signed [24:0] e_q;
	logic signed [25:0] diff_q, esum_q;
	logic signed [59:0] prod_q;
	logic signed [59:0] p_q, dterm_q;
	logic signed [60:0] isum_q;
	logic signed [47:0] raw_q;
	logic signed [65:0] t_q, u_q;
	logic signed [61:0] total_q;
	logic use_i_q;

	// Output register.
	logic m_valid_q;
	logic [31:0] drive_q;
	logic clamped_q;

	logic start, busy, active;
	ctrl_t ctrl;
	logic signed [24:0] e_in;
	logic signed [32:0] mul_a;
	logic signed [26:0] mul_b;
	logic signed [59:0] inc;
	logic [63:0] ilim_wide;
	logic [47:0] ilim, isat_lim;
	logic [24:0] e_abs;
	logic go;
	logic signed [45:0] y;
	logic signed [45:0] ylim;

	function automatic logic signed [47:0] sat_to(input logic signed [65:0] x,
			input logic [47:0] lim);
		logic signed [65:0] l;
		l = $signed({18'd0, lim});
		if (x > l) begin
			return $signed(lim);
		end else if (x < -l) begin
			return -$signed(lim);
		end
		return x[47:0];
	endfunction

	function automatic logic signed [45:0] drive_next(input logic signed [45:0] v,
			input logic signed [45:0] lim);
		if (v > lim) begin
			return lim;
		end else if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !busy;
	assign start = s_axis_tvalid && !busy;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = drive_q;
	assign m_axis_tuser = clamped_q;

	pcm_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.filt(mode_q == MODE_FILTERED),
		.hold(m_valid_q && !m_axis_tready),
		.busy(busy),
		.active(active),
		.ctrl(ctrl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			integ_limit_q <= '1;
			out_limit_q <= '1;
			sep_band_q <= '0;
			deriv_alpha_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[2:0];
				REG_GAIN_P: gain_p_q <= cfg_data;
				REG_GAIN_I: gain_i_q <= cfg_data;
				REG_GAIN_D: gain_d_q <= cfg_data;
				REG_INTEG_LIMIT: integ_limit_q <= cfg_data[30:0];
				REG_OUT_LIMIT: out_limit_q <= cfg_data[30:0];
				REG_SEP_BAND: sep_band_q <= cfg_data[23:0];
				REG_DERIV_ALPHA: deriv_alpha_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Error and its neighbors are formed as the request is accepted.
	assign e_in = 25'($signed(s_axis_tdata[23:0])) - 25'($signed(s_axis_tdata[47:24]));

	always_comb begin
		case (ctrl.a_sel)
			A_GAIN_P: mul_a = $signed({1'b0, gain_p_q});
			A_GAIN_I: mul_a = $signed({1'b0, gain_i_q});
			A_GAIN_D: mul_a = $signed({1'b0, gain_d_q});
			A_ALPHA: mul_a = $signed({17'd0, deriv_alpha_q});
			default: mul_a = '0;
		endcase
		case (ctrl.b_sel)
			B_ERR: mul_b = 27'(e_q);
			B_DIFF: mul_b = 27'(diff_q);
			B_IERR: mul_b = (mode_q == MODE_TRAPEZOID) ? 27'(esum_q) : 27'(e_q);
			B_RAW_LO: mul_b = $signed({3'd0, raw_q[23:0]});
			B_RAW_HI: mul_b = 27'($signed(raw_q[47:24]));
			B_PD_LO: mul_b = $signed({3'd0, prev_deriv_q[23:0]});
			B_PD_HI: mul_b = 27'($signed(prev_deriv_q[47:24]));
			default: mul_b = '0;
		endcase
	end

	// Integrator increment, bound and the gate that decides whether it moves, plus the scaled output and its limit.
	always_comb begin
		inc = (mode_q == MODE_TRAPEZOID) ? (prod_q >>> 1) : prod_q;
		ilim_wide = 64'(integ_limit_q) << FRAC_BITS;
		ilim = (ilim_wide > 64'(SAT48)) ? SAT48 : ilim_wide[47:0];
		isat_lim = (mode_q == MODE_ANTIWINDUP) ? SAT48 : ilim;
		e_abs = e_q[24] ? 25'(-e_q) : 25'(e_q);
		go = 1'b1;
		if (mode_q == MODE_SEPARATE) begin
			go = e_abs <= 25'(sep_band_q);
		end else if (mode_q == MODE_ANTIWINDUP) begin
			if (33'(prev_out_q) > WINDUP_HIGH) begin
				go = e_q <= 25'sd0;
			end else if (33'(prev_out_q) < WINDUP_LOW) begin
				go = e_q > 25'sd0;
			end
		end
		y = 46'(total_q >>> FRAC_BITS);
		ylim = $signed({15'd0, out_limit_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			integ_q <= '0;
			prev_deriv_q <= '0;
			prev_out_q <= '0;
			m_valid_q <= 1'b0;
			use_i_q <= 1'b1;
		end else begin
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (active) begin
				case (ctrl.op)
					OP_INTEG: begin
						if (go) begin
							integ_q <= sat_to(66'(isum_q), isat_lim);
						end
						use_i_q <= (mode_q != MODE_SEPARATE) || go;
					end
					OP_OUT: begin
						m_valid_q <= 1'b1;
						prev_error_q <= e_q;
						prev_out_q <= 32'(drive_next(y, ylim));
						if (mode_q == MODE_FILTERED) begin
							prev_deriv_q <= dterm_q[47:0];
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (start) begin
			e_q <= e_in;
			diff_q <= 26'(e_in) - 26'(prev_error_q);
			esum_q <= 26'(e_in) + 26'(prev_error_q);
		end
		prod_q <= 60'(mul_a) * 60'(mul_b);
		if (active) begin
			case (ctrl.op)
				OP_LOAD_P: p_q <= prod_q;
				OP_LOAD_D: dterm_q <= prod_q;
				OP_ISUM: isum_q <= 61'(integ_q) + 61'(inc);
				OP_RAW: raw_q <= sat_to(66'(dterm_q), SAT48);
				OP_T_LOAD: t_q <= 66'(prod_q);
				OP_T_ACC: t_q <= t_q + (66'(prod_q) <<< 24);
				OP_T_SUB: begin
					// t now holds raw*(65536 - alpha).
					t_q <= (66'(raw_q) <<< 16) - t_q;
					u_q <= 66'(prod_q);
				end
				OP_F_SHIFT: begin
					u_q <= u_q + (66'(prod_q) <<< 24);
					t_q <= t_q >>> 16;
				end
				OP_F_DONE: dterm_q <= 60'(sat_to(t_q + (u_q >>> 16), SAT48));
				OP_TOTAL: total_q <= 62'(p_q) + 62'(dterm_q)
						+ (use_i_q ? 62'(integ_q) : 62'sd0);
				OP_OUT: begin
					drive_q <= 32'(drive_next(y, ylim));
					clamped_q <= (y > ylim) || (y < -ylim);
				end
				default: ;
			endcase
		end
	end

endmodule
